// ===== hw/rtl/crxpe_pkg.sv =====
// Shared types, field constants and GF(2^8) tables for the Cauchy RS XOR parity encoder.
// Self-contained; imported by crxpe_coef, the top level and the testbench.
package crxpe_pkg;

  localparam int FIELD_BITS  = 8;
  localparam int FIELD_ORDER = 255;
  localparam logic [8:0] FIELD_POLY = 9'h11D;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ORIGINAL  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_REDUNDANT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NUM_SEGMENTS  = 2'd2;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] packet_index;
    logic [2:0] slice;
    logic [5:0] segment;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] parity_word;
    logic        status;
  } result_t;

  typedef logic [255:0][7:0] gf_tab_t;

  function automatic gf_tab_t gf_build_exp();
    gf_tab_t    t;
    logic [8:0] cur;
    t   = '0;
    cur = 9'd1;
    for (int i = 0; i < FIELD_ORDER; i++) begin
      t[i] = cur[7:0];
      cur  = {cur[7:0], 1'b0};
      if (cur[8]) cur = cur ^ FIELD_POLY;
    end
    t[FIELD_ORDER] = t[0];
    return t;
  endfunction

  function automatic gf_tab_t gf_build_log();
    gf_tab_t    t;
    logic [8:0] cur;
    t   = '0;
    cur = 9'd1;
    for (int i = 0; i < FIELD_ORDER; i++) begin
      t[cur[7:0]] = 8'(i);
      cur = {cur[7:0], 1'b0};
      if (cur[8]) cur = cur ^ FIELD_POLY;
    end
    return t;
  endfunction

  localparam gf_tab_t EXP_TABLE = gf_build_exp();
  localparam gf_tab_t LOG_TABLE = gf_build_log();

endpackage

// ===== hw/rtl/crxpe_coef.sv =====
// Cauchy matrix element unit: bit slice of the eight bit rows of 1/(r^c^255).
// Uses crxpe_pkg tables; output registered.
module crxpe_coef (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] col,
  input  logic [7:0] row,
  input  logic [2:0] slice,
  output logic [7:0] mask
);
  import crxpe_pkg::*;

  logic [7:0] elt;
  logic [7:0] lg;
  logic [7:0] e;
  logic [8:0] pos [8];
  logic [7:0] mask_next;

  always_comb begin
    elt = row ^ col ^ 8'hFF;
    lg  = LOG_TABLE[elt];
    // log of zero reads as zero, so the element degenerates to one
    e   = (lg == 8'd0) ? 8'd0 : 8'hFF - lg;
    for (int k = 0; k < FIELD_BITS; k++) begin
      pos[k] = {1'b0, e} + 9'(k);
      if (pos[k] >= 9'(FIELD_ORDER)) pos[k] = pos[k] - 9'(FIELD_ORDER);
      mask_next[k] = EXP_TABLE[pos[k][7:0]][slice];
    end
  end

  always_ff @(posedge clk) begin
    if (en) mask <= mask_next;
  end

endmodule

// ===== hw/rtl/crxpe_store.sv =====
// Parity word store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module crxpe_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cauchy_rs_xor_parity_encoder.sv =====
// Top level of the Cauchy Reed-Solomon XOR parity encoder over GF(2^8), poly 0x11D.
// Uses crxpe_pkg, crxpe_coef and crxpe_store.

// The block keeps MAX_REDUNDANT x MAX_SEGMENTS parity words of 64 bits (byte k = parity
// slice k). An absorb word (op 0) XORs its data byte into word (r, segment) of every
// active parity row r, lane k taking the byte when bit 'slice' of alpha^(e+k) is set,
// where alpha^e = 1/(r ^ packet_index ^ 255). A read word (op 1) returns word
// (packet_index, segment) and clears it. Every input word yields one result word;
// status 1 flags an index outside the configured range and nothing changes. One shared
// read-modify-write path over the single-port-read, single-port-write store does the
// work, one parity row per cycle over the R active rows, R being the minimum of
// num_redundant and MAX_REDUNDANT; each word holds the input until its result is
// loaded into the output register. After reset the block clears the store one word
// per cycle, all MAX_REDUNDANT * MAX_SEGMENTS words (1024 by default), and stalls
// input meanwhile; configuration writes are taken at any time but must only change
// while the block is idle. A finished result waits in the output register while
// the next input word is taken.
module cauchy_rs_xor_parity_encoder #(
  parameter int MAX_REDUNDANT = 16,
  parameter int MAX_SEGMENTS  = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crxpe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [crxpe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  crxpe_pkg::item_t                    item,
  input  logic                                item_valid,
  output logic                                item_stall,
  output crxpe_pkg::result_t                  result,
  output logic                                result_valid,
  input  logic                                result_stall
);
  import crxpe_pkg::*;

  localparam int DEPTH = MAX_REDUNDANT * MAX_SEGMENTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = $clog2(MAX_REDUNDANT + 1);

  // sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ABS   = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_RDZ   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // configuration
  logic [7:0] num_original;
  logic [4:0] num_redundant;
  logic [6:0] num_segments;

  // control and held word
  logic [2:0]    state, state_next;
  item_t         cur, cur_next;
  logic          status, status_next;
  logic [63:0]   word, word_next;
  logic [RW-1:0] row, row_next;
  logic [AW-1:0] row_base, row_base_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          wb_valid, wb_valid_next;
  logic [AW-1:0] wb_addr, wb_addr_next;
  logic          result_valid_next;
  result_t       result_next;

  // derived
  logic [RW-1:0] rows_eff;
  logic          seg_ok, abs_ok, rd_ok, accept, load_out;
  logic [63:0]   lane_word;
  logic [AW-1:0] item_addr;

  // store and coefficient unit
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [63:0]   st_wdata, st_rdata;
  logic [7:0]    coef_mask;

  crxpe_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  crxpe_coef u_coef (
    .clk   (clk),
    .en    (state == S_ABS),
    .col   (cur.packet_index),
    .row   (8'(row)),
    .slice (cur.slice),
    .mask  (coef_mask)
  );

  // configuration registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      num_original  <= 8'd1;
      num_redundant <= 5'd1;
      num_segments  <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_ORIGINAL:  num_original  <= cfg_data[7:0];
        REG_NUM_REDUNDANT: num_redundant <= cfg_data[4:0];
        REG_NUM_SEGMENTS:  num_segments  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // active row count, capped at the store's row capacity
  always_comb begin
    if (32'(num_redundant) > MAX_REDUNDANT) rows_eff = RW'(MAX_REDUNDANT);
    else                                    rows_eff = RW'(num_redundant);
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  // range checks on the incoming word
  assign seg_ok = (7'(item.segment) < num_segments) && (32'(item.segment) < MAX_SEGMENTS);
  assign abs_ok = (item.packet_index < num_original) && seg_ok;
  assign rd_ok  = (32'(item.packet_index) < 32'(rows_eff)) && seg_ok;

  // row base of a read; only meaningful once the row index passed its check
  assign item_addr = AW'(item.packet_index) * AW'(MAX_SEGMENTS);

  // spread the data byte over the lanes picked by the element's bit rows
  always_comb begin
    for (int k = 0; k < FIELD_BITS; k++) begin
      lane_word[8*k +: 8] = coef_mask[k] ? cur.data_byte : 8'd0;
    end
  end

  // store port steering: clearing pass, pending absorb write-back, read-and-clear
  always_comb begin
    st_we    = 1'b0;
    st_waddr = wb_addr;
    st_wdata = st_rdata ^ lane_word;
    if (state == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_addr;
      st_wdata = '0;
    end else if (wb_valid) begin
      st_we = 1'b1;
    end else if (state == S_RDZ) begin
      st_we    = 1'b1;
      st_waddr = row_base + AW'(cur.segment);
      st_wdata = '0;
    end
    st_re    = (state == S_ABS) || (state == S_RD);
    st_raddr = row_base + AW'(cur.segment);
  end

  assign load_out = (state == S_DONE) && (!result_valid || !result_stall);

  // sequencer
  always_comb begin
    state_next        = state;
    cur_next          = cur;
    status_next       = status;
    word_next         = word;
    row_next          = row;
    row_base_next     = row_base;
    clr_addr_next     = clr_addr;
    wb_valid_next     = 1'b0;
    wb_addr_next      = wb_addr;
    result_next       = result;
    result_valid_next = result_valid;

    if (result_valid && !result_stall) result_valid_next = 1'b0;

    case (state)
      S_CLEAR: begin
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cur_next      = item;
          word_next     = '0;
          row_next      = '0;
          status_next   = 1'b0;
          row_base_next = '0;
          if (item.op == OP_ABSORB) begin
            if (!abs_ok) begin
              status_next = 1'b1;
              state_next  = S_DONE;
            end else if (rows_eff == '0) begin
              state_next = S_DONE;
            end else begin
              state_next = S_ABS;
            end
          end else begin
            if (!rd_ok) begin
              status_next = 1'b1;
              state_next  = S_DONE;
            end else begin
              row_base_next = item_addr;
              state_next    = S_RD;
            end
          end
        end
      end
      S_ABS: begin
        // read row r now, write it back next cycle while row r+1 is read
        wb_valid_next = 1'b1;
        wb_addr_next  = st_raddr;
        row_next      = row + RW'(1);
        row_base_next = row_base + AW'(MAX_SEGMENTS);
        if (row == rows_eff - RW'(1)) state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = S_DONE;
      end
      S_RD: begin
        state_next = S_RDZ;
      end
      S_RDZ: begin
        word_next  = st_rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          result_next.parity_word = word;
          result_next.status      = status;
          result_valid_next       = 1'b1;
          state_next              = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      wb_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      wb_valid     <= wb_valid_next;
      result_valid <= result_valid_next;
    end
  end

  // payload registers hold no reset
  always_ff @(posedge clk) begin
    cur      <= cur_next;
    status   <= status_next;
    word     <= word_next;
    row      <= row_next;
    row_base <= row_base_next;
    wb_addr  <= wb_addr_next;
    result   <= result_next;
  end

endmodule

// ===== bench/tb_cauchy_rs_xor_parity_encoder.sv =====
// Self-checking testbench for cauchy_rs_xor_parity_encoder: drives absorb/read words,
// predicts every result word from its own GF(2^8) Cauchy parity model and compares.
// Depends on crxpe_pkg and the cauchy_rs_xor_parity_encoder RTL only.
module tb_cauchy_rs_xor_parity_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import crxpe_pkg::*;

  localparam int MAX_ROWS = 16;
  localparam int MAX_SEGS = 64;

  // Index 3 decodes to no register; a write there must leave all sizes alone.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  item_t   item = '0;
  logic    item_valid = 1'b0;
  logic    item_stall;
  result_t result;
  logic    result_valid;
  logic    result_stall = 1'b0;

  cauchy_rs_xor_parity_encoder #(
    .MAX_REDUNDANT(MAX_ROWS),
    .MAX_SEGMENTS (MAX_SEGS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (item),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

  // ---------------------------------------------------------------------------
  // Parity model state: our own field tables, the parity store and the sizes.
  // ---------------------------------------------------------------------------
  logic [7:0]  gf_exp [0:255];
  logic [7:0]  gf_log [0:255];
  logic [63:0] parity_mem [0:MAX_ROWS*MAX_SEGS-1];
  logic [7:0]  cfg_original;
  logic [4:0]  cfg_redundant;
  logic [6:0]  cfg_segments;

  item_t   words_to_send[$];
  result_t parity_results_due[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count = 0;

  // Oversized row/segment counts saturate at the store dimensions.
  function automatic int active_rows();
    return (cfg_redundant > MAX_ROWS) ? MAX_ROWS : int'(cfg_redundant);
  endfunction

  function automatic int active_segs();
    return (cfg_segments > MAX_SEGS) ? MAX_SEGS : int'(cfg_segments);
  endfunction

  // Walk alpha = 2 through the field; log(0) stays 0, exp wraps at 255.
  task automatic build_gf_tables();
    logic [8:0] acc;
    acc = 9'd1;
    for (int i = 0; i < 256; i++) gf_log[i] = 8'd0;
    for (int i = 0; i < 255; i++) begin
      gf_exp[i] = acc[7:0];
      gf_log[acc[7:0]] = 8'(i);
      acc = {acc[7:0], 1'b0};
      if (acc[8]) acc = acc ^ 9'h11D;
    end
    gf_exp[255] = gf_exp[0];
  endtask

  // Apply one word to the model and return the result word it must produce.
  // Absorb: for every active row r the Cauchy element 1/(r ^ c ^ 255) is
  // expanded into 8 bit rows alpha^(e+k); lane k takes the byte when bit
  // 'slice' of row k is set. A zero element reads log 0, so it acts as 1.
  function automatic result_t compute_parity_result(item_t w);
    result_t     res;
    int          rows;
    int          segs;
    int          e;
    int          addr;
    logic [7:0]  elt;
    logic [7:0]  rowbits;
    logic [63:0] lanes;
    res  = '0;
    res.status = STATUS_OK;
    rows = active_rows();
    segs = active_segs();
    if (w.op == OP_ABSORB) begin
      if (w.packet_index >= cfg_original || w.segment >= segs) begin
        res.status = STATUS_RANGE;
      end else begin
        for (int r = 0; r < rows; r++) begin
          elt   = 8'(r) ^ w.packet_index ^ 8'hFF;
          e     = (255 - int'(gf_log[elt])) % 255;
          lanes = '0;
          for (int k = 0; k < 8; k++) begin
            rowbits = gf_exp[(e + k) % 255];
            if (rowbits[w.slice]) lanes[8*k +: 8] = w.data_byte;
          end
          addr = r * MAX_SEGS + int'(w.segment);
          parity_mem[addr] = parity_mem[addr] ^ lanes;
        end
      end
    end else begin
      if (w.packet_index >= rows || w.segment >= segs) begin
        res.status = STATUS_RANGE;
      end else begin
        addr = int'(w.packet_index) * MAX_SEGS + int'(w.segment);
        res.parity_word = parity_mem[addr];
        parity_mem[addr] = '0;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: present queued words, predict each one at the edge it is taken.
  // A stalled word holds its payload; valid only changes once the slot frees.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        parity_results_due = {parity_results_due, compute_parity_result(item)};
      end
      if (!item_valid || !item_stall) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item       <= words_to_send.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: match every taken result word against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t due;
    if (!rst && result_valid && !result_stall) begin
      if (parity_results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, got parity %h status %0d",
                 $time, result.parity_word, result.status);
      end else begin
        due = parity_results_due.pop_front();
        if (result.parity_word !== due.parity_word || result.status !== due.status) begin
          mismatch_count++;
          $display({"%0t: result mismatch, expected parity %h status %0d,",
                    " got parity %h status %0d"},
                   $time, due.parity_word, due.status, result.parity_word, result.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_word(logic op, int idx, int slc, int seg, int data);
    item_t w;
    w.op           = op;
    w.packet_index = 8'(idx);
    w.slice        = 3'(slc);
    w.segment      = 6'(seg);
    w.data_byte    = 8'(data);
    words_to_send = {words_to_send, w};
  endtask

  // Sample at the falling edge so queue and valid are settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (words_to_send.size() != 0 || item_valid || parity_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Registers only change while nothing is in flight; mirror them in the model.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_ORIGINAL:  cfg_original  = value;
      REG_NUM_REDUNDANT: cfg_redundant = value[4:0];
      REG_NUM_SEGMENTS:  cfg_segments  = value[6:0];
      default: ;
    endcase
  endtask

  task automatic program_sizes(logic [7:0] orig, logic [7:0] red, logic [7:0] segs);
    wait_idle();
    write_reg(REG_NUM_ORIGINAL, orig);
    write_reg(REG_NUM_REDUNDANT, red);
    write_reg(REG_NUM_SEGMENTS, segs);
  endtask

  // One encoded stripe: absorb a few bytes at one segment, then drain every
  // parity row of that segment so the accumulated words come back out.
  task automatic add_stripe(ref int count);
    int seg;
    int n;
    seg = $urandom_range(active_segs() - 1);
    n   = $urandom_range(6, 1);
    for (int i = 0; i < n; i++)
      send_word(OP_ABSORB, $urandom_range(int'(cfg_original) - 1), $urandom_range(7),
                seg, $urandom_range(255));
    for (int r = 0; r < active_rows(); r++)
      send_word(OP_READ, r, $urandom_range(7), seg, $urandom_range(255));
    count += n + active_rows();
  endtask

  // Mostly well-formed stripes and in-range words, some raw noise.
  task automatic random_phase(logic [7:0] orig, logic [7:0] red, logic [7:0] segs, int words);
    int count;
    int pick;
    count = 0;
    program_sizes(orig, red, segs);
    while (count < words) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        add_stripe(count);
      end else if (pick < 85) begin
        if ($urandom_range(1))
          send_word(OP_ABSORB, $urandom_range(int'(cfg_original) - 1), $urandom_range(7),
                    $urandom_range(active_segs() - 1), $urandom_range(255));
        else
          send_word(OP_READ, $urandom_range(active_rows() - 1), $urandom_range(7),
                    $urandom_range(active_segs() - 1), $urandom_range(255));
        count++;
      end else begin
        send_word(1'($urandom_range(1)), $urandom_range(255), $urandom_range(7),
                  $urandom_range(63), $urandom_range(255));
        count++;
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    build_gf_tables();
    for (int i = 0; i < MAX_ROWS * MAX_SEGS; i++) parity_mem[i] = '0;
    cfg_original   = 8'd1;
    cfg_redundant  = 5'd1;
    cfg_segments   = 7'd1;
    send_idle_pct  = 7;
    recv_stall_pct = 85;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: one column, one row, one segment; anything else is flagged.
    send_word(OP_ABSORB, 0, 0, 0, 8'hFF);
    send_word(OP_ABSORB, 1, 0, 0, 8'h11);
    send_word(OP_ABSORB, 0, 5, 1, 8'h22);
    send_word(OP_READ, 0, 0, 0, 8'h00);
    send_word(OP_READ, 1, 0, 0, 8'h00);

    // Full width with oversized row/segment counts that must saturate.
    // Column 254 hits the zero field element on row 1.
    program_sizes(8'd255, 8'hFF, 8'hFF);
    send_word(OP_ABSORB, 254, 7, 63, 8'hA5);
    send_word(OP_ABSORB, 0, 3, 63, 8'h5A);
    send_word(OP_ABSORB, 128, 0, 63, 8'h80);
    send_word(OP_ABSORB, 255, 1, 0, 8'h01);
    send_word(OP_READ, 0, 0, 63, 8'h00);
    send_word(OP_READ, 1, 7, 63, 8'hFF);
    send_word(OP_READ, 15, 0, 63, 8'h00);
    send_word(OP_READ, 16, 0, 0, 8'h00);
    send_word(OP_READ, 0, 0, 0, 8'h00);

    // Zero sizes flag everything.
    program_sizes(8'd0, 8'd0, 8'd0);
    send_word(OP_ABSORB, 0, 0, 0, 8'h33);
    send_word(OP_READ, 0, 0, 0, 8'h00);

    // No parity rows: absorb is accepted but changes nothing; reads are flagged.
    program_sizes(8'd4, 8'd0, 8'd2);
    send_word(OP_ABSORB, 3, 2, 1, 8'hC3);
    send_word(OP_READ, 0, 0, 1, 8'h00);
    wait_idle();
    write_reg(REG_UNUSED, 8'h00);
    program_sizes(8'd4, 8'd1, 8'd2);
    send_word(OP_ABSORB, 3, 6, 1, 8'h3C);
    send_word(OP_READ, 0, 0, 1, 8'h00);

    random_phase(8'd255, 8'd16, 8'd64, 150);
    random_phase(8'd1, 8'd1, 8'd1, 150);

    // Swap the idle pattern: slow sender, eager receiver.
    send_idle_pct  = 85;
    recv_stall_pct = 7;
    random_phase(8'd20, 8'd5, 8'd3, 150);
    random_phase(8'd255, 8'h3F, 8'd8, 150);

    // Full rate both ways.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_phase(8'd200, 8'd12, 8'd64, 150);
    random_phase(8'd7, 8'd16, 8'd2, 150);

    // Let any stray result word show up before judging.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run including the store clear.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
